// ----- hdl/hhf_pkg.sv -----
// ============================================================================
// hhf_pkg: shared types and constants of the heap hole-fill extract unit
// Tree geometry, key width, request and response payloads, and the control
// and status bundles passed between the sequencer and the presence tracker.
// ============================================================================
package hhf_pkg;

   localparam int LEVELS    = 5;
   localparam int KEY_WIDTH = 16;
   localparam int NSLOTS    = 1 << LEVELS;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   typedef struct packed {
      logic                 op;
      logic [LEVELS-1:0]    slot;
      logic [KEY_WIDTH-1:0] key_in;
      logic                 present_in;
   } req_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] min_key;
      logic                 taken;
      logic [LEVELS-1:0]    remaining;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [LEVELS-1:0] slot;
      logic              value;
   } upd_type;

   typedef struct packed {
      logic              root_present;
      logic              hole_present;
      logic              left_present;
      logic              right_present;
      logic [LEVELS:0]   live_count;
   } stat_type;

endpackage

// ----- hdl/hhf_ram.sv -----
// ============================================================================
// hhf_ram: generic synchronous RAM
// One write port and two read ports, each with a registered read.
// ============================================================================
module hhf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- hdl/hhf_presence.sv -----
// ============================================================================
// hhf_presence: slot presence flags and live count
// Holds one present flag per slot, cleared by reset, and the count of set
// flags. Reports the root, the hole and both children of the hole.
// ============================================================================
module hhf_presence (
   input  logic                      clock,
   input  logic                      reset,
   input  hhf_pkg::upd_type          upd,
   input  logic [hhf_pkg::LEVELS-1:0] hole,
   output hhf_pkg::stat_type         stat
);

   logic [hhf_pkg::NSLOTS-1:0] flags_ff;
   logic [hhf_pkg::NSLOTS-1:0] flags_in;
   logic [hhf_pkg::LEVELS:0]   live_count_ff;
   logic [hhf_pkg::LEVELS:0]   live_count_in;
   logic [hhf_pkg::LEVELS:0]   left_idx;
   logic [hhf_pkg::LEVELS:0]   right_idx;

   assign left_idx  = {hole, 1'b0};
   assign right_idx = {hole, 1'b1};

   always_comb begin
      flags_in      = flags_ff;
      live_count_in = live_count_ff;
      if (upd.en && (upd.slot != '0)) begin
         flags_in[upd.slot] = upd.value;
         if (upd.value && !flags_ff[upd.slot]) begin
            live_count_in = live_count_ff + 1'b1;
         end else if (!upd.value && flags_ff[upd.slot]) begin
            live_count_in = live_count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff      <= '0;
         live_count_ff <= '0;
      end else begin
         flags_ff      <= flags_in;
         live_count_ff <= live_count_in;
      end
   end

   always_comb begin
      stat.root_present  = flags_ff[1];
      stat.hole_present  = flags_ff[hole];
      stat.left_present  = !left_idx[hhf_pkg::LEVELS] &&
                           flags_ff[left_idx[hhf_pkg::LEVELS-1:0]];
      stat.right_present = !right_idx[hhf_pkg::LEVELS] &&
                           flags_ff[right_idx[hhf_pkg::LEVELS-1:0]];
      stat.live_count    = live_count_ff;
   end

`ifndef SYNTHESIS
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(flags_ff) == int'(live_count_ff))
      else $error("Live count differs from the number of present flags.");

   a_slot_zero_clear: assert property (@(posedge clock) disable iff (reset)
      !flags_ff[0])
      else $error("Slot zero is marked present.");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      int'(live_count_ff) < hhf_pkg::NSLOTS)
      else $error("Live count exceeds the number of slots.");
`endif

endmodule

// ----- hdl/heap_hole_fill_extract_min_unit.sv -----
// ============================================================================
// heap_hole_fill_extract_min_unit: min-heap extract by hole filling
// Keeps a binary min-heap in a key RAM plus presence flags. A load request
// writes one slot; an extract request removes the root key and sinks the hole.
// ============================================================================
// Usage:
// A request is taken at a rising edge where start is high and busy is low.
// A load request completes at that edge, produces no response, and keeps
// busy low, so another request may follow in the next cycle.
// An extract request on an empty root answers in the next cycle and keeps
// busy low. Otherwise the unit reads the root key, then walks down one tree
// level per cycle: the key RAM returns both children of the hole, the smaller
// present child is copied up, and the reads for the next level go out in the
// same cycle. An extract that ends with the hole at depth h (1 to LEVELS)
// holds busy through S_ROOT and one S_WALK step per level down to that depth;
// its response is registered as the unit returns to S_IDLE. The walk through
// the key RAM sets its length. The next request may be taken in the response cycle.
// rsp_strobe marks a response for exactly one cycle; the receiver cannot
// stall it. Reset clears all presence flags and the live count; key RAM
// contents are undefined until loaded.
// ============================================================================
module heap_hole_fill_extract_min_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hhf_pkg::req_type req_data,
   output logic             rsp_strobe,
   output hhf_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ROOT,
      S_WALK
   } state_type;

   state_type                       state_ff;
   state_type                       state_in;
   logic [hhf_pkg::LEVELS-1:0]      hole_ff;
   logic [hhf_pkg::LEVELS-1:0]      hole_in;
   logic [hhf_pkg::KEY_WIDTH-1:0]   min_key_ff;
   logic [hhf_pkg::KEY_WIDTH-1:0]   min_key_in;
   logic                            rsp_strobe_ff;
   logic                            rsp_strobe_in;
   hhf_pkg::rsp_type                rsp_data_ff;
   hhf_pkg::rsp_type                rsp_data_in;

   logic                            accept;
   logic [hhf_pkg::LEVELS-1:0]      next_hole;
   logic                            ram_we;
   logic [hhf_pkg::LEVELS-1:0]      ram_waddr;
   logic [hhf_pkg::KEY_WIDTH-1:0]   ram_wdata;
   logic [hhf_pkg::LEVELS-1:0]      ram_raddr_a;
   logic [hhf_pkg::LEVELS-1:0]      ram_raddr_b;
   logic [hhf_pkg::KEY_WIDTH-1:0]   key_left;
   logic [hhf_pkg::KEY_WIDTH-1:0]   key_right;
   logic                            pick_left;
   logic [hhf_pkg::LEVELS:0]        count_less_one;
   hhf_pkg::upd_type                upd;
   hhf_pkg::stat_type               stat;

   assign busy           = (state_ff != S_IDLE);
   assign accept         = start && !busy;
   assign count_less_one = stat.live_count - 1'b1;

   always_comb begin
      if (stat.left_present && stat.right_present) begin
         pick_left = (key_left <= key_right);
      end else begin
         pick_left = stat.left_present;
      end
   end

   always_comb begin
      state_in      = state_ff;
      hole_in       = hole_ff;
      min_key_in    = min_key_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      next_hole     = hole_ff;
      ram_we        = 1'b0;
      ram_waddr     = req_data.slot;
      ram_wdata     = req_data.key_in;
      ram_raddr_a   = hhf_pkg::LEVELS'(1);
      ram_raddr_b   = hhf_pkg::LEVELS'(1);
      upd.en        = 1'b0;
      upd.slot      = req_data.slot;
      upd.value     = req_data.present_in;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.op == hhf_pkg::OP_LOAD) begin
                  ram_we = (req_data.slot != '0);
                  upd.en = 1'b1;
               end else if (stat.root_present) begin
                  state_in = S_ROOT;
               end else begin
                  rsp_strobe_in         = 1'b1;
                  rsp_data_in.min_key   = '0;
                  rsp_data_in.taken     = 1'b0;
                  rsp_data_in.remaining = stat.live_count[hhf_pkg::LEVELS-1:0];
               end
            end
         end
         S_ROOT: begin
            min_key_in  = key_left;
            next_hole   = hhf_pkg::LEVELS'(1);
            hole_in     = next_hole;
            ram_raddr_a = {next_hole[hhf_pkg::LEVELS-2:0], 1'b0};
            ram_raddr_b = {next_hole[hhf_pkg::LEVELS-2:0], 1'b1};
            state_in    = S_WALK;
         end
         S_WALK: begin
            if (!stat.left_present && !stat.right_present) begin
               upd.en                = 1'b1;
               upd.slot              = hole_ff;
               upd.value             = 1'b0;
               rsp_strobe_in         = 1'b1;
               rsp_data_in.min_key   = min_key_ff;
               rsp_data_in.taken     = 1'b1;
               rsp_data_in.remaining = count_less_one[hhf_pkg::LEVELS-1:0];
               state_in              = S_IDLE;
            end else begin
               next_hole   = {hole_ff[hhf_pkg::LEVELS-2:0], !pick_left};
               ram_we      = 1'b1;
               ram_waddr   = hole_ff;
               ram_wdata   = pick_left ? key_left : key_right;
               ram_raddr_a = {next_hole[hhf_pkg::LEVELS-2:0], 1'b0};
               ram_raddr_b = {next_hole[hhf_pkg::LEVELS-2:0], 1'b1};
               hole_in     = next_hole;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      hole_ff     <= hole_in;
      min_key_ff  <= min_key_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   hhf_ram #(
      .WIDTH (hhf_pkg::KEY_WIDTH),
      .DEPTH (hhf_pkg::NSLOTS)
   ) u_key_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr_a (ram_raddr_a),
      .rd_data_a (key_left),
      .rd_addr_b (ram_raddr_b),
      .rd_data_b (key_right)
   );

   hhf_presence u_presence (
      .clock (clock),
      .reset (reset),
      .upd   (upd),
      .hole  (hole_ff),
      .stat  (stat)
   );

`ifndef SYNTHESIS
   a_hole_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (hole_ff != '0))
      else $error("Hole points at slot zero during the walk.");

   a_hole_present: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> stat.hole_present)
      else $error("Hole sits on a slot that is not present.");

   a_taken_after_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.taken) |-> ($past(state_ff) == S_WALK))
      else $error("Extracted key reported without a walk.");
`endif

endmodule
